// ===== rtl/core/kbq_pkg.sv =====
// ----------------------------------------------------------------------------
// kbq_pkg
// Shared types and constants for the keyboard event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kbq_pkg;

  localparam int unsigned KEY_COUNT   = 256;
  localparam int unsigned KEY_W       = $clog2(KEY_COUNT);
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned WORD_W      = 13;
  localparam int unsigned MOD_COUNT   = 9;

  typedef enum logic [2:0] {
    MODE_EVENT   = 3'd0,
    MODE_POP     = 3'd1,
    MODE_DOWNCNT = 3'd2,
    MODE_UPCNT   = 3'd3,
    MODE_DOWNTIM = 3'd4,
    MODE_FLUSH   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Modifier keys, in the order of the shadow pressed bits.
  localparam logic [7:0] MOD_KEYS [MOD_COUNT] = '{
    8'h2A, 8'h36,   // shift
    8'hB8, 8'h38,   // alt (right, left)
    8'h1D, 8'h9D,   // ctrl
    8'h9E, 8'h9F,   // meta
    8'hD3           // delete
  };

  typedef struct packed {
    logic        pressed;
    logic        level;
    logic        prev_level;
    logic [7:0]  down_cnt;
    logic [7:0]  up_cnt;
    logic [31:0] went_down;
    logic [31:0] held;
  } key_entry_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [31:0]       stamp;
  } queue_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/keyboard_event_queue.sv =====
// ----------------------------------------------------------------------------
// keyboard_event_queue
// Per-key state tracker with a timestamped key word queue.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    mode, key_code, key_down, now_time
// out_      output     out_valid/out_ready  item_valid, key_word, key_time,
//                                           event_count, held_time
// cfg_      input      cfg_we (no wait)     repeat_enable
//
// On accept the block issues the reads of the key state RAM and the queue
// RAM; in the execute state it modifies the entry, writes it back and loads
// the result register. A flush, and reset, run a clearing pass over all 256
// entries of the key RAM, during which no request is accepted.
// A result waiting in the output register lets the next request be accepted;
// that request then holds in the execute state until the result is taken.
`default_nettype none

module keyboard_event_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_repeat_enable,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_key_code,
  input  wire logic        in_key_down,
  input  wire logic [31:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_item_valid,
  output logic [12:0]      out_key_word,
  output logic [31:0]      out_key_time,
  output logic [7:0]       out_event_count,
  output logic [31:0]      out_held_time
);

  localparam int unsigned KW = kbq_pkg::KEY_W;
  localparam int unsigned QW = kbq_pkg::QPTR_W;
  localparam int unsigned EW = $bits(kbq_pkg::key_entry_t);
  localparam int unsigned QEW = $bits(kbq_pkg::queue_entry_t);

  kbq_pkg::state_t state_r, state_nxt;

  logic            repeat_en_r;
  logic [2:0]      mode_r;
  logic [KW-1:0]   key_r;
  logic            down_r;
  logic [31:0]     now_r;
  logic [31:0]     flush_time_r, flush_time_nxt;
  logic [KW:0]     clr_cnt_r, clr_cnt_nxt;
  logic [QW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [kbq_pkg::MOD_COUNT-1:0] mod_r, mod_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            o_item_r, o_item_nxt;
  logic [12:0]     o_word_r, o_word_nxt;
  logic [31:0]     o_time_r, o_time_nxt;
  logic [7:0]      o_cnt_r, o_cnt_nxt;
  logic [31:0]     o_held_r, o_held_nxt;

  // Key RAM ports.
  logic                 k_we;
  logic [KW-1:0]        k_waddr, k_raddr;
  logic [EW-1:0]        k_rdata;
  kbq_pkg::key_entry_t  k_old, k_new;

  // Queue RAM ports.
  logic                   q_we;
  logic [QEW-1:0]         q_rdata;
  kbq_pkg::queue_entry_t  q_old, q_new;

  logic          commit;
  logic          enq;
  logic [QW-1:0] tail_inc, head_inc;
  logic [12:0]   word;

  assign k_old = kbq_pkg::key_entry_t'(k_rdata);
  assign q_old = kbq_pkg::queue_entry_t'(q_rdata);
  assign k_raddr = (state_r == kbq_pkg::ST_IDLE) ? in_key_code : key_r;

  kbq_ram #(.WIDTH(EW), .DEPTH(kbq_pkg::KEY_COUNT)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (EW'(k_new)),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  kbq_ram #(.WIDTH(QEW), .DEPTH(kbq_pkg::QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (QEW'(q_new)),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  assign in_ready        = (state_r == kbq_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_item_valid  = o_item_r;
  assign out_key_word    = o_word_r;
  assign out_key_time    = o_time_r;
  assign out_event_count = o_cnt_r;
  assign out_held_time   = o_held_r;

  assign commit   = (state_r == kbq_pkg::ST_EXEC) && (!out_valid_r || out_ready);
  assign tail_inc = (tail_r == QW'(kbq_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == QW'(kbq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    flush_time_nxt = flush_time_r;
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    mod_nxt        = mod_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_item_nxt     = o_item_r;
    o_word_nxt     = o_word_r;
    o_time_nxt     = o_time_r;
    o_cnt_nxt      = o_cnt_r;
    o_held_nxt     = o_held_r;
    k_we           = 1'b0;
    k_waddr        = key_r;
    k_new          = k_old;
    q_we           = 1'b0;
    q_new.stamp    = now_r;
    enq            = 1'b0;
    word           = '0;

    // Entry update for each key mode, and modifier flags from the updated pressed bits.
    if (mode_r == kbq_pkg::MODE_EVENT) begin
      if (down_r) begin
        if (!k_old.pressed) begin
          k_new.pressed   = 1'b1;
          k_new.down_cnt  = k_old.down_cnt + 8'd1;
          k_new.level     = 1'b1;
          k_new.went_down = now_r;
        end
      end else begin
        k_new.pressed = 1'b0;
        k_new.up_cnt  = k_old.up_cnt + {7'd0, k_old.level};
        k_new.level   = 1'b0;
        k_new.held    = k_old.held + (now_r - k_old.went_down);
      end
      k_new.prev_level = down_r;
      for (int i = 0; i < kbq_pkg::MOD_COUNT; i++) begin
        if (key_r == kbq_pkg::MOD_KEYS[i]) begin
          mod_nxt[i] = k_new.pressed;
        end
      end
      enq = down_r && (!k_old.prev_level || repeat_en_r);
    end else if (mode_r == kbq_pkg::MODE_DOWNCNT) begin
      k_new.down_cnt = '0;
    end else if (mode_r == kbq_pkg::MODE_UPCNT) begin
      k_new.up_cnt = '0;
    end else if (mode_r == kbq_pkg::MODE_DOWNTIM) begin
      if (!k_old.pressed) begin
        k_new.held = '0;
      end else begin
        k_new.went_down = now_r;
      end
    end
    word = {mod_nxt[7] | mod_nxt[6], mod_nxt[8], mod_nxt[5] | mod_nxt[4],
            mod_nxt[3] | mod_nxt[2], mod_nxt[1] | mod_nxt[0], key_r};
    q_new.word = word;

    unique case (state_r)
      kbq_pkg::ST_CLEAR: begin
        k_we            = 1'b1;
        k_waddr         = clr_cnt_r[KW-1:0];
        k_new           = '0;
        k_new.level     = 1'b1;
        k_new.went_down = flush_time_r;
        clr_cnt_nxt     = clr_cnt_r + 1'b1;
        if (clr_cnt_r[KW-1:0] == KW'(kbq_pkg::KEY_COUNT - 1)) begin
          state_nxt = kbq_pkg::ST_IDLE;
        end
      end
      kbq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = kbq_pkg::ST_EXEC;
        end
      end
      kbq_pkg::ST_EXEC: begin
        if (commit) begin
          state_nxt     = kbq_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          o_item_nxt    = 1'b0;
          o_word_nxt    = '0;
          o_time_nxt    = '0;
          o_cnt_nxt     = '0;
          o_held_nxt    = '0;
          case (mode_r)
            kbq_pkg::MODE_EVENT: begin
              k_we = 1'b1;
              if (enq && (tail_inc != head_r)) begin
                q_we     = 1'b1;
                tail_nxt = tail_inc;
              end
            end
            kbq_pkg::MODE_POP: begin
              if (head_r != tail_r) begin
                o_item_nxt = 1'b1;
                o_word_nxt = q_old.word;
                o_time_nxt = q_old.stamp;
                head_nxt   = head_inc;
              end
            end
            kbq_pkg::MODE_DOWNCNT: begin
              k_we      = 1'b1;
              o_cnt_nxt = k_old.down_cnt;
            end
            kbq_pkg::MODE_UPCNT: begin
              k_we      = 1'b1;
              o_cnt_nxt = k_old.up_cnt;
            end
            kbq_pkg::MODE_DOWNTIM: begin
              k_we       = 1'b1;
              o_held_nxt = k_old.pressed ? (now_r - k_old.went_down) : k_old.held;
            end
            kbq_pkg::MODE_FLUSH: begin
              state_nxt      = kbq_pkg::ST_CLEAR;
              flush_time_nxt = now_r;
              clr_cnt_nxt    = '0;
              head_nxt       = '0;
              tail_nxt       = '0;
              mod_nxt        = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = kbq_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kbq_pkg::ST_CLEAR;
      repeat_en_r  <= 1'b1;
      flush_time_r <= '0;
      clr_cnt_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      mod_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flush_time_r <= flush_time_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      // The modifier bits only follow a committed request; the request
      // registers hold no meaningful value before the first accept.
      mod_r        <= commit ? mod_nxt : mod_r;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        repeat_en_r <= cfg_repeat_enable;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      key_r  <= in_key_code;
      down_r <= in_key_down;
      now_r  <= in_now_time;
    end
    o_item_r <= o_item_nxt;
    o_word_r <= o_word_nxt;
    o_time_r <= o_time_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_held_r <= o_held_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kbq_ram.sv =====
// ----------------------------------------------------------------------------
// kbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kbq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== test/keyboard_event_queue_tb.sv =====
// ----------------------------------------------------------------------------
// keyboard_event_queue_tb
// Self-checking bench for the keyboard event queue. A behavioral model of
// the per-key state and the key word ring predicts every result, and each
// result is compared field by field, in part under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyboard_event_queue_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_repeat_enable = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [7:0]  in_key_code = '0;
  logic        in_key_down = 1'b0;
  logic [31:0] in_now_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_item_valid;
  logic [12:0] out_key_word;
  logic [31:0] out_key_time;
  logic [7:0]  out_event_count;
  logic [31:0] out_held_time;

  keyboard_event_queue dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_repeat_enable(cfg_repeat_enable),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_key_code(in_key_code),
    .in_key_down(in_key_down), .in_now_time(in_now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_item_valid(out_item_valid), .out_key_word(out_key_word),
    .out_key_time(out_key_time), .out_event_count(out_event_count),
    .out_held_time(out_held_time)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic        item_valid;
    logic [12:0] key_word;
    logic [31:0] key_time;
    logic [7:0]  event_count;
    logic [31:0] held_time;
  } key_result_t;

  // Shadow copy of the block's state.
  logic              mdl_repeat;
  logic              mdl_pressed [kbq_pkg::KEY_COUNT];
  logic              mdl_level   [kbq_pkg::KEY_COUNT];
  logic              mdl_prev    [kbq_pkg::KEY_COUNT];
  logic [7:0]        mdl_down    [kbq_pkg::KEY_COUNT];
  logic [7:0]        mdl_up      [kbq_pkg::KEY_COUNT];
  logic [31:0]       mdl_went    [kbq_pkg::KEY_COUNT];
  logic [31:0]       mdl_held    [kbq_pkg::KEY_COUNT];
  logic [12:0]       mdl_qword   [kbq_pkg::QUEUE_DEPTH];
  logic [31:0]       mdl_qtime   [kbq_pkg::QUEUE_DEPTH];
  logic [kbq_pkg::QPTR_W-1:0] mdl_head, mdl_tail;

  key_result_t pending_results[$];
  bit          failed = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] clock_now = 32'd0;

  function automatic void model_flush(logic [31:0] now);
    mdl_head = '0;
    mdl_tail = '0;
    for (int i = 0; i < kbq_pkg::QUEUE_DEPTH; i++) begin
      mdl_qword[i] = '0;
      mdl_qtime[i] = '0;
    end
    for (int i = 0; i < kbq_pkg::KEY_COUNT; i++) begin
      mdl_pressed[i] = 1'b0;
      mdl_level[i]   = 1'b1;
      mdl_prev[i]    = 1'b0;
      mdl_went[i]    = now;
      mdl_down[i]    = '0;
      mdl_up[i]      = '0;
      mdl_held[i]    = '0;
    end
  endfunction

  // Applies one request to the shadow state and returns what the block owes.
  function automatic key_result_t model_key_request(logic [2:0] mode, logic [7:0] k,
                                                    logic down, logic [31:0] now);
    key_result_t r;
    logic [12:0] w;
    r = '0;
    case (mode)
      kbq_pkg::MODE_EVENT: begin
        if (down) begin
          if (!mdl_pressed[k]) begin
            mdl_pressed[k] = 1'b1;
            mdl_down[k] = mdl_down[k] + 8'd1;
            mdl_level[k] = 1'b1;
            mdl_went[k] = now;
          end
        end else begin
          mdl_pressed[k] = 1'b0;
          mdl_up[k] = mdl_up[k] + {7'd0, mdl_level[k]};
          mdl_level[k] = 1'b0;
          mdl_held[k] = mdl_held[k] + (now - mdl_went[k]);
        end
        if (down && (!mdl_prev[k] || mdl_repeat)) begin
          w = {5'd0, k};
          if (mdl_pressed[8'h2A] || mdl_pressed[8'h36]) w |= 13'h100;
          if (mdl_pressed[8'h38] || mdl_pressed[8'hB8]) w |= 13'h200;
          if (mdl_pressed[8'h1D] || mdl_pressed[8'h9D]) w |= 13'h400;
          if (mdl_pressed[8'h9E] || mdl_pressed[8'h9F]) w |= 13'h1000;
          if (mdl_pressed[8'hD3]) w |= 13'h800;
          // A full ring drops the new word without notice.
          if (kbq_pkg::QPTR_W'(mdl_tail + 1) != mdl_head) begin
            mdl_qword[mdl_tail] = w;
            mdl_qtime[mdl_tail] = now;
            mdl_tail = mdl_tail + 1'b1;
          end
        end
        mdl_prev[k] = down;
      end
      kbq_pkg::MODE_POP: begin
        if (mdl_head != mdl_tail) begin
          r.item_valid = 1'b1;
          r.key_word = mdl_qword[mdl_head];
          r.key_time = mdl_qtime[mdl_head];
          mdl_head = mdl_head + 1'b1;
        end
      end
      kbq_pkg::MODE_DOWNCNT: begin
        r.event_count = mdl_down[k];
        mdl_down[k] = '0;
      end
      kbq_pkg::MODE_UPCNT: begin
        r.event_count = mdl_up[k];
        mdl_up[k] = '0;
      end
      kbq_pkg::MODE_DOWNTIM: begin
        if (!mdl_pressed[k]) begin
          r.held_time = mdl_held[k];
          mdl_held[k] = '0;
        end else begin
          r.held_time = now - mdl_went[k];
          mdl_went[k] = now;
        end
      end
      kbq_pkg::MODE_FLUSH: model_flush(now);
      default: ;
    endcase
    return r;
  endfunction

  // Sends one request: idles first at random, then holds valid until taken.
  // Valid is left high after the accept; the next request takes it over or a drain drops it.
  task automatic send_request(logic [2:0] mode, logic [7:0] k, logic down,
                              logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_key_code <= k;
    in_key_down <= down;
    in_now_time <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(model_key_request(mode, k, down, now));
    @(negedge clk);
  endtask

  // Time that mostly moves forward, with the odd wild value.
  function automatic logic [31:0] next_time();
    if ($urandom_range(15) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(200000);
    return clock_now;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Only written with the block drained, so the shadow copy follows at once.
  task automatic write_repeat(logic val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_repeat_enable <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    mdl_repeat = val;
  endtask

  // Receiver: random stalls, checks every taken result against the oldest.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    key_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_item_valid !== e.item_valid) begin
          $error("item_valid: expected %0h, actual %0h", e.item_valid, out_item_valid);
          failed = 1'b1;
        end
        if (out_key_word !== e.key_word) begin
          $error("key_word: expected %0h, actual %0h", e.key_word, out_key_word);
          failed = 1'b1;
        end
        if (out_key_time !== e.key_time) begin
          $error("key_time: expected %0h, actual %0h", e.key_time, out_key_time);
          failed = 1'b1;
        end
        if (out_event_count !== e.event_count) begin
          $error("event_count: expected %0h, actual %0h", e.event_count, out_event_count);
          failed = 1'b1;
        end
        if (out_held_time !== e.held_time) begin
          $error("held_time: expected %0h, actual %0h", e.held_time, out_held_time);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: a flush clear pass stays well inside the quiet limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [7:0] mods [9] = '{8'h2A, 8'h36, 8'h38, 8'hB8, 8'h1D, 8'h9D,
                             8'h9E, 8'h9F, 8'hD3};
    // Empty pop, then a press and a repeat of key 0, read back all counts.
    send_request(kbq_pkg::MODE_POP, 8'h00, 1'b0, 32'h0);
    send_request(kbq_pkg::MODE_EVENT, 8'h00, 1'b1, 32'h7FFF_FFFF);
    send_request(kbq_pkg::MODE_EVENT, 8'h00, 1'b1, 32'h8000_0000);
    send_request(kbq_pkg::MODE_DOWNTIM, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_request(kbq_pkg::MODE_EVENT, 8'h00, 1'b0, 32'h0000_0001);
    send_request(kbq_pkg::MODE_EVENT, 8'hFF, 1'b0, 32'h1234_5678);
    send_request(kbq_pkg::MODE_DOWNCNT, 8'h00, 1'b0, 32'h0);
    send_request(kbq_pkg::MODE_UPCNT, 8'h00, 1'b1, 32'h0);
    send_request(kbq_pkg::MODE_DOWNTIM, 8'h00, 1'b0, 32'h0);
    // Every modifier held at once flags a plain key press.
    foreach (mods[i]) send_request(kbq_pkg::MODE_EVENT, mods[i], 1'b1, 32'h100 + i);
    send_request(kbq_pkg::MODE_EVENT, 8'h41, 1'b1, 32'h200);
    for (int i = 0; i < 14; i++) send_request(kbq_pkg::MODE_POP, 8'h00, 1'b0, 32'h0);
    send_request(3'd6, 8'hAA, 1'b1, 32'hFFFF_FFFF);
    send_request(3'd7, 8'h55, 1'b0, 32'h0);
    send_request(kbq_pkg::MODE_FLUSH, 8'h00, 1'b0, 32'h0001_0000);
    send_request(kbq_pkg::MODE_DOWNTIM, 8'h00, 1'b0, 32'h0002_0000);
  endtask

  // Repeats with repeat off, and an overfilled ring.
  task automatic test_queue_full();
    write_repeat(1'b0);
    send_request(kbq_pkg::MODE_EVENT, 8'h10, 1'b1, 32'h10);
    send_request(kbq_pkg::MODE_EVENT, 8'h10, 1'b1, 32'h11);
    write_repeat(1'b1);
    for (int i = 0; i < 20; i++) begin
      send_request(kbq_pkg::MODE_EVENT, 8'h10, 1'b1, 32'h20 + i);
    end
    for (int i = 0; i < 17; i++) send_request(kbq_pkg::MODE_POP, 8'h00, 1'b0, 32'h0);
    // Let every result land before anything else is asked.
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [2:0] mode;
    logic [7:0] k;
    int sel;
    logic [7:0] mod_keys [8] = '{8'h2A, 8'h36, 8'h38, 8'hB8, 8'h1D, 8'h9D,
                                 8'h9E, 8'h9F};
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 45) mode = kbq_pkg::MODE_EVENT;
      else if (sel < 70) mode = kbq_pkg::MODE_POP;
      else if (sel < 79) mode = kbq_pkg::MODE_DOWNCNT;
      else if (sel < 88) mode = kbq_pkg::MODE_UPCNT;
      else if (sel < 97) mode = kbq_pkg::MODE_DOWNTIM;
      else if (sel < 98) mode = kbq_pkg::MODE_FLUSH;
      else mode = 3'($urandom_range(7, 6));
      // Mostly a small key set including modifiers so that state builds up.
      case ($urandom_range(3))
        0: k = 8'($urandom);
        1: k = mod_keys[$urandom_range(7)];
        default: k = 8'($urandom_range(7));
      endcase
      if ($urandom_range(19) == 0) k = 8'hD3;
      send_request(mode, k, 1'($urandom), next_time());
    end
  endtask

  initial begin
    mdl_repeat = 1'b1;
    model_flush(32'd0);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_queue_full();
    send_idle_pct = 11; recv_idle_pct = 82;
    test_random(600);
    write_repeat(1'b0);
    send_idle_pct = 82; recv_idle_pct = 11;
    test_random(600);
    write_repeat(1'b1);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(650);
    wait_drained();
    repeat (20) @(negedge clk);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
